// ----- rtl/xfbp_pkg.sv -----
// Shared types and constants for the XOR-checksum frame byte parser.
package xfbp_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned ERR_W   = 16;

    // Packed stream widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 56;   // 49 bits of fields, padded to 7 bytes
    localparam int unsigned M_TUSER_W = EVENT_W;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_HEADER = 1'b0;  // word index of header_value

    // Frame positions with fixed meaning
    localparam logic [BYTE_W-1:0] POS_LENGTH  = 8'd1;
    localparam logic [BYTE_W-1:0] POS_COMMAND = 8'd2;
    localparam logic [BYTE_W-1:0] POS_DATA0   = 8'd3;

    // Result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 2'd0,
        EV_DATA     = 2'd1,
        EV_SUM_GOOD = 2'd2,
        EV_SUM_BAD  = 2'd3
    } event_t;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_COMMAND = 5'b00100,
        PH_DATA    = 5'b01000,
        PH_CHECK   = 5'b10000
    } phase_t;

    // One result item
    typedef struct packed {
        logic              link_up;
        logic [ERR_W-1:0]  error_total;
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] frame_command;
        logic [BYTE_W-1:0] data_index;
        logic [BYTE_W-1:0] data_value;
        event_t            event_res;
    } result_t;

endpackage

// ----- rtl/xfbp_core.sv -----
// Frame parser state and per-byte update logic.
module xfbp_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_take,
    input  logic [xfbp_pkg::BYTE_W-1:0] rx_byte,
    input  logic [xfbp_pkg::BYTE_W-1:0] header_value,
    output xfbp_pkg::result_t           result
);
    import xfbp_pkg::*;

    phase_t            phase_reg,    phase_next;
    logic [BYTE_W-1:0] position_reg, position_next;
    logic [BYTE_W-1:0] length_reg,   length_next;
    logic [BYTE_W-1:0] command_reg,  command_next;
    logic [BYTE_W-1:0] xor_reg,      xor_next;
    logic [ERR_W-1:0]  errs_reg,     errs_next;
    logic              link_reg,     link_next;
    event_t            ev;
    logic [BYTE_W-1:0] dval;
    logic [BYTE_W-1:0] didx;

    // Next state and result for the byte at the input
    always_comb begin
        phase_next    = phase_reg;
        position_next = position_reg;
        length_next   = length_reg;
        command_next  = command_reg;
        xor_next      = xor_reg;
        errs_next     = errs_reg;
        link_next     = link_reg;
        ev            = EV_NONE;
        dval          = '0;
        didx          = '0;
        case (phase_reg)
            PH_HEADER: begin
                if (rx_byte == header_value) begin
                    xor_next      = rx_byte;
                    position_next = POS_LENGTH;
                    phase_next    = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                length_next = rx_byte;
                if (rx_byte >= POS_LENGTH) xor_next = xor_reg ^ rx_byte;
                position_next = POS_COMMAND;
                phase_next    = PH_COMMAND;
            end
            PH_COMMAND: begin
                command_next = rx_byte;
                if (length_reg >= POS_COMMAND) xor_next = xor_reg ^ rx_byte;
                position_next = POS_DATA0;
                phase_next    = PH_DATA;
            end
            PH_DATA: begin
                // only bytes up to the length position count in the sum
                if (position_reg <= length_reg) xor_next = xor_reg ^ rx_byte;
                ev   = EV_DATA;
                dval = rx_byte;
                didx = position_reg - POS_DATA0;
                if (position_reg >= length_reg) phase_next = PH_CHECK;
                else position_next = position_reg + 8'd1;
            end
            PH_CHECK: begin
                phase_next = PH_HEADER;
                if (xor_reg == rx_byte) begin
                    link_next = 1'b1;
                    ev        = EV_SUM_GOOD;
                end else begin
                    link_next = 1'b0;
                    errs_next = errs_reg + 16'd1;
                    ev        = EV_SUM_BAD;
                end
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    // Result carries the state as it stands after this byte
    always_comb begin
        result.event_res     = ev;
        result.data_value    = dval;
        result.data_index    = didx;
        result.frame_command = command_next;
        result.frame_length  = length_next;
        result.error_total   = errs_next;
        result.link_up       = link_next;
    end

    // State registers, advanced once per accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            position_reg <= '0;
            length_reg   <= '0;
            command_reg  <= '0;
            xor_reg      <= '0;
            errs_reg     <= '0;
            link_reg     <= 1'b0;
        end else if (byte_take) begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            length_reg   <= length_next;
            command_reg  <= command_next;
            xor_reg      <= xor_next;
            errs_reg     <= errs_next;
            link_reg     <= link_next;
        end
    end

endmodule

// ----- rtl/xor_frame_byte_parser.sv -----
// Top level: byte stream in, parse results out, APB header register.
//
//  Channel   Ports                       Carries
//  s_        s_tvalid/s_tready/s_tdata   one received byte per request
//  m_        m_tvalid/m_tready/m_tdata   one parse result per input byte
//            m_tuser                     event code of that result
//  APB       psel/penable/pwrite/...     header_value at byte address 0
//
// One byte is taken per cycle while s_tready is high; the parser state and XOR
// update sit between the input handshake and the result register, so each
// result is registered (in the skid stage when the result register is full).
// Reset (synchronous, aresetn low) returns to header hunt and clears counters.
// The result register is backed by a one-entry skid stage: s_tready drops only
// when both hold unread results, and rises again as soon as one is taken.
module xor_frame_byte_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [xfbp_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [xfbp_pkg::M_TDATA_W-1:0]     m_tdata,   // [7:0] data_value,
                                                          // [15:8] data_index,
                                                          // [23:16] frame_command,
                                                          // [31:24] frame_length,
                                                          // [47:32] error_total,
                                                          // [48] link_up, rest 0
    output logic [xfbp_pkg::M_TUSER_W-1:0]     m_tuser,   // [1:0] event_res
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [xfbp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [xfbp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [xfbp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import xfbp_pkg::*;

    logic [BYTE_W-1:0] header_reg;
    logic              reg_sel;
    logic              s_take;
    logic              m_take;
    result_t           core_result;

    result_t out_reg,        out_next;
    logic    out_valid_reg,  out_valid_next;
    result_t skid_reg,       skid_next;
    logic    skid_valid_reg, skid_valid_next;

    // APB register file
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_HEADER);
    assign prdata  = reg_sel ? {{(APB_DATA_W-BYTE_W){1'b0}}, header_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            header_reg <= pwdata[BYTE_W-1:0];
        end
    end

    // Handshakes
    assign s_tready = !skid_valid_reg;
    assign s_take   = s_tvalid && s_tready;
    assign m_take   = out_valid_reg && m_tready;

    xfbp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_take    (s_take),
        .rx_byte      (s_tdata[BYTE_W-1:0]),
        .header_value (header_reg),
        .result       (core_result)
    );

    // Result register with skid stage
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (m_take) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (s_take) begin
            if (!out_valid_reg || m_take) begin
                out_next       = core_result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = core_result;
                skid_valid_next = 1'b1;
            end
        end else if (m_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {7'd0,
                       out_reg.link_up,
                       out_reg.error_total,
                       out_reg.frame_length,
                       out_reg.frame_command,
                       out_reg.data_index,
                       out_reg.data_value};

endmodule
